@@ hdl/fgpd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fgpd_pkg
// Types, constants, rule tables and the step program of the fuzzy-gain PD
// steering block.
// ----------------------------------------------------------------------------
package fgpd_pkg;

    // default band edges for the error and the error change
    localparam int E_SMALL_DEF   = 40;
    localparam int E_MEDIUM_DEF  = 100;
    localparam int E_BIG_DEF     = 200;
    localparam int EC_SMALL_DEF  = 5;
    localparam int EC_MEDIUM_DEF = 15;
    localparam int EC_BIG_DEF    = 30;

    // register indexes on the write port
    localparam logic [2:0] REG_BASE_P      = 3'd0;
    localparam logic [2:0] REG_BASE_D      = 3'd1;
    localparam logic [2:0] REG_CENTER_DUTY = 3'd2;
    localparam logic [2:0] REG_RANGE_LEFT  = 3'd3;
    localparam logic [2:0] REG_RANGE_RIGHT = 3'd4;

    // reset values of the registers
    localparam logic [9:0]  BASE_P_RST      = 10'd225;
    localparam logic [9:0]  BASE_D_RST      = 10'd150;
    localparam logic [15:0] CENTER_DUTY_RST = 16'd1500;
    localparam logic [11:0] RANGE_LEFT_RST  = 12'd200;
    localparam logic [11:0] RANGE_RIGHT_RST = 12'd200;

    // road classes
    localparam logic [1:0] ROAD_STRAIGHT = 2'd0;

    // fixed-point factors (Q0.16 or plain integers)
    localparam logic [9:0]  KP_NEAR   = 10'd655;   // 0.01
    localparam logic [9:0]  KP_FAR    = 10'd393;   // 0.006
    localparam logic [9:0]  KOUT_P    = 10'd983;   // 0.015
    localparam logic [12:0] KOUT_D    = 13'd6554;  // 0.1
    localparam logic [10:0] NEAR_EDGE = 11'd177;
    localparam logic [6:0]  D_NEAR    = 7'd100;
    localparam logic [6:0]  D_FAR     = 7'd10;
    localparam logic signed [10:0] LOST_EDGE   = 11'sd20;
    localparam logic signed [15:0] LOST_MARGIN = 16'sd40;

    // rule-table steps in Q16.16, rounded to nearest
    localparam logic [21:0] STEP_P1 =
        22'((64'd333 * 64'd35259 * 64'd65536 + 64'd500000) / 64'd1000000);
    localparam logic [21:0] STEP_P2 =
        22'((64'd667 * 64'd35259 * 64'd65536 + 64'd500000) / 64'd1000000);
    localparam logic [21:0] STEP_P3 =
        22'((64'd895 * 64'd35259 * 64'd65536 + 64'd500000) / 64'd1000000);
    localparam logic [21:0] STEP_D1 =
        22'((64'd333 * 64'd70518 * 64'd65536 + 64'd500000) / 64'd1000000);
    localparam logic [21:0] STEP_D2 =
        22'((64'd667 * 64'd70518 * 64'd65536 + 64'd500000) / 64'd1000000);
    localparam logic [21:0] STEP_D3 =
        22'((64'd895 * 64'd70518 * 64'd65536 + 64'd500000) / 64'd1000000);

    // 7x7 rules, row = error class, column = error-change class
    localparam logic signed [2:0] RULE_P [7][7] = '{
        '{3'sd3, 3'sd3, 3'sd2, 3'sd2, 3'sd1, 3'sd0, 3'sd0},
        '{3'sd3, 3'sd3, 3'sd2, 3'sd1, 3'sd1, 3'sd0, 3'sd1},
        '{3'sd2, 3'sd2, 3'sd2, 3'sd1, 3'sd0, 3'sd1, 3'sd1},
        '{3'sd2, 3'sd2, 3'sd1, 3'sd0, 3'sd1, 3'sd2, 3'sd2},
        '{3'sd1, 3'sd1, 3'sd0, 3'sd1, 3'sd1, 3'sd2, 3'sd2},
        '{3'sd1, 3'sd0, 3'sd1, 3'sd2, 3'sd2, 3'sd2, 3'sd3},
        '{3'sd0, 3'sd0, 3'sd2, 3'sd2, 3'sd2, 3'sd3, 3'sd3}
    };

    localparam logic signed [2:0] RULE_D [7][7] = '{
        '{ 3'sd1,  3'sd1, -3'sd3,  3'sd3, -3'sd3,  3'sd2,  3'sd1},
        '{ 3'sd1,  3'sd1, -3'sd3,  3'sd2, -3'sd2,  3'sd1,  3'sd0},
        '{ 3'sd0,  3'sd1, -3'sd2,  3'sd2, -3'sd1,  3'sd1,  3'sd0},
        '{ 3'sd0,  3'sd1, -3'sd1,  3'sd1, -3'sd1,  3'sd1,  3'sd0},
        '{ 3'sd0,  3'sd0,  3'sd0,  3'sd2,  3'sd0,  3'sd0,  3'sd0},
        '{ 3'sd3,  3'sd1,  3'sd1,  3'sd2,  3'sd1,  3'sd1,  3'sd3},
        '{ 3'sd3,  3'sd2,  3'sd2,  3'sd3,  3'sd1,  3'sd1,  3'sd3}
    };

    typedef struct packed {
        logic signed [10:0] track_error;
        logic [1:0]         road_kind;
    } frame_t;

    typedef struct packed {
        logic [15:0]        duty;
        logic signed [15:0] drive;
    } steer_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_SQ,      // x = |e| * |e|, d = straight D
        OP_KP,      // x = x * straight P factor
        OP_LDFZ,    // x, d = fuzzy P, D
        OP_KE,      // y = 983 * e
        OP_PE,      // acc = x * y
        OP_KEC,     // y = 6554 * ec
        OP_DEC,     // prod = d * y
        OP_ADD,     // acc = acc + prod
        OP_DRV,     // drive from acc, lost-line override
        OP_DUTY     // duty window, load result word
    } op_t;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_FUZZY
    } cond_t;

    typedef struct packed {
        op_t        op;
        cond_t      cond;
        logic [3:0] target;
    } ucode_t;

    localparam logic [3:0] STEP_LAST = 4'd9;

    function automatic ucode_t ucode_rom(input logic [3:0] step);
        ucode_t w;
        unique case (step)
            4'd0:    w = '{op: OP_SQ,   cond: COND_FUZZY,  target: 4'd2};
            4'd1:    w = '{op: OP_KP,   cond: COND_ALWAYS, target: 4'd3};
            4'd2:    w = '{op: OP_LDFZ, cond: COND_NEXT,   target: 4'd0};
            4'd3:    w = '{op: OP_KE,   cond: COND_NEXT,   target: 4'd0};
            4'd4:    w = '{op: OP_PE,   cond: COND_NEXT,   target: 4'd0};
            4'd5:    w = '{op: OP_KEC,  cond: COND_NEXT,   target: 4'd0};
            4'd6:    w = '{op: OP_DEC,  cond: COND_NEXT,   target: 4'd0};
            4'd7:    w = '{op: OP_ADD,  cond: COND_NEXT,   target: 4'd0};
            4'd8:    w = '{op: OP_DRV,  cond: COND_NEXT,   target: 4'd0};
            default: w = '{op: OP_DUTY, cond: COND_NEXT,   target: 4'd0};
        endcase
        return w;
    endfunction

    // seven-way banding; tests run in this order whatever the edges
    function automatic logic [2:0] band(
        input logic signed [12:0] x,
        input logic [11:0]        s,
        input logic [11:0]        m,
        input logic [11:0]        b
    );
        logic signed [12:0] ns;
        logic signed [12:0] nm;
        logic signed [12:0] nb;
        logic [2:0]         r;
        ns = -$signed({1'b0, s});
        nm = -$signed({1'b0, m});
        nb = -$signed({1'b0, b});
        if (x < 13'sd0) begin
            if (x < nb)      r = 3'd0;
            else if (x < nm) r = 3'd1;
            else if (x < ns) r = 3'd2;
            else             r = 3'd3;
        end else begin
            if (x > $signed({1'b0, b}))      r = 3'd6;
            else if (x > $signed({1'b0, m})) r = 3'd5;
            else if (x > $signed({1'b0, s})) r = 3'd4;
            else                             r = 3'd3;
        end
        return r;
    endfunction

    // signed step of a rule code; magnitude from the low two bits of |code|
    function automatic logic signed [22:0] rule_step(
        input logic signed [2:0] code,
        input logic              is_d
    );
        logic [2:0]  neg;
        logic [1:0]  mag;
        logic [21:0] val;
        neg = 3'(-code);
        mag = code[2] ? neg[1:0] : code[1:0];
        unique case (mag)
            2'd0: val = 22'd0;
            2'd1: val = is_d ? STEP_D1 : STEP_P1;
            2'd2: val = is_d ? STEP_D2 : STEP_P2;
            2'd3: val = is_d ? STEP_D3 : STEP_P3;
            default: val = 22'd0;
        endcase
        return code[2] ? -$signed({1'b0, val}) : $signed({1'b0, val});
    endfunction

endpackage
`default_nettype wire

@@ hdl/fuzzy_gain_pd_steering.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_gain_pd_steering
// Fuzzy-gain PD steering: one servo duty and drive word per frame word.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  frame     in         frame_valid / frame_ready     frame_t  {track_error, road_kind}
//  steer     out        steer_valid / steer_ready     steer_t  {duty, drive}
//  config    in         wr_en (no wait)               wr_index, wr_data
//
//  Sequence: a frame word is taken when the block is idle, then 9 of the 10
//  microprogram words run on one shared 32x26 multiplier (straight and fuzzy
//  gains each skip the other's load step); the last word loads the output
//  register and returns the block to idle, and only then can the next frame
//  word be taken.
//  Reset: rst_n clears control, the previous error and the registers to
//  their defaults; no clearing pass.
//  Stalls: a pending result does not block the next frame word; only the
//  last step waits while the output register still holds an untaken word.
//
module fuzzy_gain_pd_steering
    import fgpd_pkg::*;
#(
    parameter int E_SMALL   = E_SMALL_DEF,
    parameter int E_MEDIUM  = E_MEDIUM_DEF,
    parameter int E_BIG     = E_BIG_DEF,
    parameter int EC_SMALL  = EC_SMALL_DEF,
    parameter int EC_MEDIUM = EC_MEDIUM_DEF,
    parameter int EC_BIG    = EC_BIG_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        frame_valid,
    output logic             frame_ready,
    input  wire frame_t      frame,
    output logic             steer_valid,
    input  wire logic        steer_ready,
    output steer_t           steer,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [15:0] wr_data
);

    localparam logic [11:0] E_S  = 12'(E_SMALL);
    localparam logic [11:0] E_M  = 12'(E_MEDIUM);
    localparam logic [11:0] E_B  = 12'(E_BIG);
    localparam logic [11:0] EC_S = 12'(EC_SMALL);
    localparam logic [11:0] EC_M = 12'(EC_MEDIUM);
    localparam logic [11:0] EC_B = 12'(EC_BIG);

    // configuration
    logic [9:0]  base_p_reg;
    logic [9:0]  base_d_reg;
    logic [15:0] center_reg;
    logic [11:0] range_left_reg;
    logic [11:0] range_right_reg;

    // control
    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    ucode_t     uw;

    // datapath
    logic signed [10:0] prev_reg;
    logic signed [10:0] e_reg;
    logic signed [11:0] ec_reg;
    logic [1:0]         road_reg;
    logic signed [31:0] x_reg;      // P in Q16.16
    logic signed [27:0] d_reg;      // D in Q16.16
    logic signed [25:0] y_reg;      // scaled e or ec
    logic signed [51:0] acc_reg;    // Q20.32 sum
    logic signed [51:0] prod_reg;
    logic signed [15:0] drive_reg;
    steer_t             out_reg;

    logic               accept;
    logic               fuzzy;
    logic               out_free;
    logic [10:0]        ae;
    logic               near;
    logic signed [31:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [57:0] mul_p;

    assign accept      = frame_valid && frame_ready;
    assign frame_ready = (state_reg == ST_IDLE);
    assign steer_valid = out_valid_reg;
    assign steer       = out_reg;
    assign fuzzy       = (road_reg != ROAD_STRAIGHT);
    assign out_free    = !out_valid_reg || steer_ready;
    assign uw          = ucode_rom(step_reg);

    assign ae   = e_reg[10] ? 11'(~e_reg + 11'sd1) : 11'(e_reg);
    assign near = (ae < NEAR_EDGE);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !steer_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    step_next  = 4'd0;
                end
            end
            ST_RUN:
            begin
                if (uw.op == OP_DUTY)
                begin
                    // final step holds until the output register is free
                    if (out_free)
                    begin
                        state_next     = ST_IDLE;
                        out_valid_next = 1'b1;
                    end
                end
                else
                begin
                    unique case (uw.cond)
                        COND_NEXT:   step_next = step_reg + 4'd1;
                        COND_ALWAYS: step_next = uw.target;
                        COND_FUZZY:  step_next = fuzzy ? uw.target : step_reg + 4'd1;
                        default:     step_next = step_reg + 4'd1;
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- configuration and previous error ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_p_reg      <= BASE_P_RST;
            base_d_reg      <= BASE_D_RST;
            center_reg      <= CENTER_DUTY_RST;
            range_left_reg  <= RANGE_LEFT_RST;
            range_right_reg <= RANGE_RIGHT_RST;
            prev_reg        <= 11'sd0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_BASE_P:      base_p_reg      <= wr_data[9:0];
                    REG_BASE_D:      base_d_reg      <= wr_data[9:0];
                    REG_CENTER_DUTY: center_reg      <= wr_data;
                    REG_RANGE_LEFT:  range_left_reg  <= wr_data[11:0];
                    REG_RANGE_RIGHT: range_right_reg <= wr_data[11:0];
                    default:         ;  // unmapped index, ignored
                endcase
            end
            if (accept)
                prev_reg <= frame.track_error;
        end
    end

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        mul_a = 32'sd0;
        mul_b = 26'sd0;
        unique case (uw.op)
            OP_SQ:
            begin
                mul_a = $signed({21'd0, ae});
                mul_b = $signed({15'd0, ae});
            end
            OP_KP:
            begin
                mul_a = x_reg;
                mul_b = $signed({16'd0, (near ? KP_NEAR : KP_FAR)});
            end
            OP_KE:
            begin
                mul_a = $signed({22'd0, KOUT_P});
                mul_b = 26'(e_reg);
            end
            OP_PE:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
            OP_KEC:
            begin
                mul_a = $signed({19'd0, KOUT_D});
                mul_b = 26'(ec_reg);
            end
            OP_DEC:
            begin
                mul_a = 32'(d_reg);
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = 32'sd0;
                mul_b = 26'sd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ---------------- fuzzy gains ----------------
    logic [2:0]         band_i, band_j;
    logic signed [2:0]  code_p, code_d;
    logic signed [31:0] p_fz;
    logic signed [27:0] d_fz;

    assign band_i = band(13'(e_reg), E_S, E_M, E_B);
    assign band_j = band(13'(ec_reg), EC_S, EC_M, EC_B);
    assign code_p = RULE_P[band_i][band_j];
    assign code_d = RULE_D[band_i][band_j];
    assign p_fz   = $signed({6'd0, base_p_reg, 16'd0}) + 32'(rule_step(code_p, 1'b0));
    assign d_fz   = $signed({2'd0, base_d_reg, 16'd0}) + 28'(rule_step(code_d, 1'b1));

    // ---------------- drive and duty ----------------
    logic signed [19:0] q_trunc;
    logic signed [15:0] drive_sat;
    logic signed [15:0] drive_val;
    logic signed [18:0] duty_sum, duty_hi, duty_lo, duty_clip;
    logic [15:0]        duty_val;

    // toward zero: floor, plus one for a negative sum with a fraction
    assign q_trunc = acc_reg[51:32] + 20'(acc_reg[51] && (acc_reg[31:0] != 32'd0));

    always_comb
    begin
        priority if (q_trunc > 20'sd32767)
            drive_sat = 16'sd32767;
        else if (q_trunc < -20'sd32768)
            drive_sat = -16'sd32768;
        else
            drive_sat = q_trunc[15:0];

        drive_val = drive_sat;
        // lost line: fixed drive once the error is clearly to one side
        if (road_reg[1])
        begin
            if (e_reg > LOST_EDGE)
                drive_val = $signed({4'd0, range_left_reg}) - LOST_MARGIN;
            if (e_reg < -LOST_EDGE)
                drive_val = LOST_MARGIN - $signed({4'd0, range_right_reg});
        end
    end

    assign duty_sum = $signed({3'd0, center_reg}) + 19'(drive_reg);
    assign duty_hi  = $signed({3'd0, center_reg}) + $signed({7'd0, range_right_reg});
    assign duty_lo  = $signed({3'd0, center_reg}) - $signed({7'd0, range_left_reg});

    always_comb
    begin
        duty_clip = duty_sum;
        if (duty_clip > duty_hi)
            duty_clip = duty_hi;
        if (duty_clip < duty_lo)
            duty_clip = duty_lo;
        priority if (duty_clip < 19'sd0)
            duty_val = 16'd0;
        else if (duty_clip > 19'sd65535)
            duty_val = 16'hFFFF;
        else
            duty_val = duty_clip[15:0];
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_reg    <= frame.track_error;
            ec_reg   <= 12'(frame.track_error) - 12'(prev_reg);
            road_reg <= frame.road_kind;
        end
        if (state_reg == ST_RUN)
        begin
            unique case (uw.op)
                OP_SQ:
                begin
                    x_reg <= mul_p[31:0];
                    d_reg <= near ? $signed({5'd0, D_NEAR, 16'd0})
                                  : $signed({5'd0, D_FAR, 16'd0});
                end
                OP_KP:   x_reg    <= mul_p[31:0];
                OP_LDFZ:
                begin
                    x_reg <= p_fz;
                    d_reg <= d_fz;
                end
                OP_KE:   y_reg    <= mul_p[25:0];
                OP_PE:   acc_reg  <= mul_p[51:0];
                OP_KEC:  y_reg    <= mul_p[25:0];
                OP_DEC:  prod_reg <= mul_p[51:0];
                OP_ADD:  acc_reg  <= acc_reg + prod_reg;
                OP_DRV:  drive_reg <= drive_val;
                OP_DUTY:
                begin
                    if (out_free)
                    begin
                        out_reg.duty  <= duty_val;
                        out_reg.drive <= drive_reg;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // a taken frame starts the program at its first step
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN) && (step_reg == 4'd0))
        else $error("program did not start at step 0");

    // the step counter never leaves the program
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= STEP_LAST))
        else $error("step counter out of program");

    // finishing the program always presents a result word
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && (uw.op == OP_DUTY) && out_free
        |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("result word not presented at end of program");

    // lost line to the right forces the left-range drive
    a_lost_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && (uw.op == OP_DRV) && road_reg[1]
        && (e_reg > LOST_EDGE)
        |=> drive_reg == $signed({4'd0, range_left_reg}) - LOST_MARGIN)
        else $error("lost-line drive mismatch");

    // the previous error follows each taken frame
    a_prev: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> prev_reg == $past(frame.track_error))
        else $error("previous error not updated");
`endif

endmodule
`default_nettype wire

@@ tb/fuzzy_gain_pd_steering_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_gain_pd_steering_tb
// Self-checking bench for the fuzzy-gain PD steering block. Frame words go
// in through a valid/ready channel with random gaps. A behavioral model of
// the gain tables and the fixed-point drive math predicts every steer word.
// The receiver stalls at random and checks each word, field by field,
// against the oldest prediction. Register settings change between phases,
// and only while the block is drained.
// ----------------------------------------------------------------------------
module fuzzy_gain_pd_steering_tb;
    import fgpd_pkg::*;

    // remaining road classes; straight comes from the package
    localparam logic [1:0] ROAD_CURVE         = 2'd1;
    localparam logic [1:0] ROAD_CURVE_LOST    = 2'd2;
    localparam logic [1:0] ROAD_STRAIGHT_LOST = 2'd3;

    // band edges, matching the block's default parameters
    localparam longint ERR_S  = 40;
    localparam longint ERR_M  = 100;
    localparam longint ERR_B  = 200;
    localparam longint DERR_S = 5;
    localparam longint DERR_M = 15;
    localparam longint DERR_B = 30;

    localparam longint Q16         = 65536;
    localparam int     RUN_LEN     = 240;   // random frames per register setting
    localparam int     STALL_LIMIT = 400;   // cycles with no handshake at all
    localparam int     DRAIN_WAIT  = 12;    // settle wait, longer than one frame's microprogram run

    // fuzzy rule tables: row = error band, column = error-change band
    localparam int P_RULES [7][7] = '{
        '{3, 3, 2, 2, 1, 0, 0},
        '{3, 3, 2, 1, 1, 0, 1},
        '{2, 2, 2, 1, 0, 1, 1},
        '{2, 2, 1, 0, 1, 2, 2},
        '{1, 1, 0, 1, 1, 2, 2},
        '{1, 0, 1, 2, 2, 2, 3},
        '{0, 0, 2, 2, 2, 3, 3}
    };
    localparam int D_RULES [7][7] = '{
        '{1, 1, -3, 3, -3, 2, 1},
        '{1, 1, -3, 2, -2, 1, 0},
        '{0, 1, -2, 2, -1, 1, 0},
        '{0, 1, -1, 1, -1, 1, 0},
        '{0, 0,  0, 2,  0, 0, 0},
        '{3, 1,  1, 2,  1, 1, 3},
        '{3, 2,  2, 3,  1, 1, 3}
    };

    // directed frames; a result is typed in only where it is obvious
    typedef struct {
        int err;
        int road;
        bit typed;
        int duty;
        int drive;
    } probe_t;

    localparam int N_PROBES = 25;
    probe_t probes [N_PROBES] = '{
        '{    0, ROAD_STRAIGHT,      1'b1, 1500,      0},  // straight ahead after reset
        '{ 1023, ROAD_STRAIGHT,      1'b1, 1700,  32767},  // positive saturation, window top
        '{-1024, ROAD_STRAIGHT,      1'b1, 1300, -32768},  // negative saturation, window bottom
        '{  176, ROAD_STRAIGHT,      1'b0,    0,      0},  // last value on the 0.01 curve
        '{  177, ROAD_STRAIGHT,      1'b0,    0,      0},  // first value on the 0.006 curve
        '{ -177, ROAD_STRAIGHT,      1'b0,    0,      0},
        '{ -176, ROAD_STRAIGHT,      1'b0,    0,      0},
        '{   21, ROAD_CURVE_LOST,    1'b1, 1660,    160},  // lost line, forced left
        '{   20, ROAD_CURVE_LOST,    1'b0,    0,      0},  // lost line, still computed
        '{  -21, ROAD_STRAIGHT_LOST, 1'b1, 1340,   -160},  // lost line, forced right
        '{  -20, ROAD_STRAIGHT_LOST, 1'b0,    0,      0},
        '{  200, ROAD_CURVE,         1'b0,    0,      0},  // error band edges
        '{  201, ROAD_CURVE,         1'b0,    0,      0},
        '{ -200, ROAD_CURVE,         1'b0,    0,      0},
        '{ -201, ROAD_CURVE,         1'b0,    0,      0},
        '{  100, ROAD_CURVE,         1'b0,    0,      0},
        '{  101, ROAD_CURVE,         1'b0,    0,      0},
        '{ -101, ROAD_CURVE,         1'b0,    0,      0},
        '{   40, ROAD_CURVE,         1'b0,    0,      0},
        '{   41, ROAD_CURVE,         1'b0,    0,      0},
        '{  -41, ROAD_CURVE,         1'b0,    0,      0},
        '{  -40, ROAD_CURVE,         1'b0,    0,      0},
        '{ 1023, ROAD_STRAIGHT_LOST, 1'b1, 1660,    160},
        '{-1024, ROAD_CURVE_LOST,    1'b1, 1340,   -160},
        '{    0, ROAD_CURVE,         1'b0,    0,      0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        frame_valid;
    logic        frame_ready;
    frame_t      frame;
    logic        steer_valid;
    logic        steer_ready;
    steer_t      steer;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [15:0] wr_data;

    // shadow of the block: registers and the remembered error
    longint cfg_base_p;
    longint cfg_base_d;
    longint cfg_center;
    longint cfg_left;
    longint cfg_right;
    longint last_err;

    steer_t steer_due [$];      // predicted steer words, oldest first

    int  err_count  = 0;
    int  n_frames   = 0;
    int  n_checked  = 0;
    int  n_settings = 1;        // reset values count as the first setting
    int  n_sat      = 0;
    int  n_forced   = 0;
    int  n_fuzzy    = 0;
    int  gen_prev   = 0;        // last generated error, steers the ec spread
    bit  src_calm   = 1'b0;     // stretches where the sender never idles
    bit  sink_calm  = 1'b0;     // same for the receiver

    fuzzy_gain_pd_steering dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .steer_valid (steer_valid),
        .steer_ready (steer_ready),
        .steer       (steer),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // seven fuzzy classes NB..PB as 0..6; tests in this fixed order
    function automatic int fuzzy_class(input longint x, input longint s, input longint m,
                                       input longint b);
        if (x < 0)
        begin
            if (x < -b) return 0;
            if (x < -m) return 1;
            if (x < -s) return 2;
            return 3;
        end
        if (x > b) return 6;
        if (x > m) return 5;
        if (x > s) return 4;
        return 3;
    endfunction

    // signed Q16.16 gain step for a rule code: 0.333/0.667/0.895 of the unit
    function automatic longint gain_step(input int code, input bit for_d);
        longint w;
        longint unit;
        longint val;
        case (code < 0 ? -code : code)
            1:       w = 333;
            2:       w = 667;
            3:       w = 895;
            default: w = 0;
        endcase
        unit = for_d ? 70518 : 35259;
        val  = (w * unit * Q16 + 500000) / 1000000;
        return code < 0 ? -val : val;
    endfunction

    // steer word for one frame; advances the remembered error
    function automatic steer_t predict_steer(input frame_t f);
        longint e;
        longint ec;
        longint ae;
        longint p;
        longint d;
        longint sum;
        longint mag;
        longint drv;
        longint duty;
        longint hi;
        longint lo;
        int     row;
        int     col;
        steer_t r;
        e  = longint'($signed(f.track_error));
        ec = e - last_err;
        ae = e < 0 ? -e : e;
        if (f.road_kind == ROAD_STRAIGHT)
        begin
            if (ae < 177)
            begin
                p = ae * ae * 655;
                d = 100 * Q16;
            end
            else
            begin
                p = ae * ae * 393;
                d = 10 * Q16;
            end
        end
        else
        begin
            row = fuzzy_class(e, ERR_S, ERR_M, ERR_B);
            col = fuzzy_class(ec, DERR_S, DERR_M, DERR_B);
            p = cfg_base_p * Q16 + gain_step(P_RULES[row][col], 1'b0);
            d = cfg_base_d * Q16 + gain_step(D_RULES[row][col], 1'b1);
            n_fuzzy++;
        end
        // Q32.32 sum, truncated toward zero, then saturated to 16 bits
        sum = 983 * p * e + 6554 * d * ec;
        mag = (sum < 0 ? -sum : sum) >> 32;
        if (mag > 40000) mag = 40000;
        drv = sum < 0 ? -mag : mag;
        if (drv > 32767 || drv < -32768) n_sat++;
        if (drv > 32767) drv = 32767;
        if (drv < -32768) drv = -32768;
        last_err = e;
        // lost line: fixed drive well away from zero error
        if (f.road_kind == ROAD_CURVE_LOST || f.road_kind == ROAD_STRAIGHT_LOST)
        begin
            if (e > 20)
            begin
                drv = cfg_left - 40;
                n_forced++;
            end
            if (e < -20)
            begin
                drv = -(cfg_right - 40);
                n_forced++;
            end
        end
        duty = cfg_center + drv;
        hi   = cfg_center + cfg_right;
        lo   = cfg_center - cfg_left;
        if (duty > hi) duty = hi;
        if (duty < lo) duty = lo;
        if (duty < 0) duty = 0;
        if (duty > 65535) duty = 65535;
        r.duty  = duty[15:0];
        r.drive = drv[15:0];
        return r;
    endfunction

    // Random frame. Three picks in ten move the error a little from the last one
    // so that every error-change band is visited; the rest jump anywhere, sit on
    // an edge, hit the field extremes, or fall within 260 of zero.
    function automatic frame_t next_frame();
        int     pick;
        int     k;
        int     marks [6] = '{20, 40, 100, 177, 200, 0};
        frame_t f;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: k = $signed(11'($urandom));
            3, 4, 5: k = gen_prev + $urandom_range(0, 90) - 45;
            6:
            begin
                k = marks[$urandom_range(0, 5)] + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1) == 1) k = -k;
            end
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       k = -1024;
                    1:       k = 1023;
                    2:       k = -1;
                    default: k = 0;
                endcase
            end
            default: k = $urandom_range(0, 520) - 260;
        endcase
        if (k > 1023) k = 1023;
        if (k < -1024) k = -1024;
        gen_prev      = k;
        f.track_error = 11'(k);
        f.road_kind   = 2'($urandom_range(0, 3));
        return f;
    endfunction

    // Offer one frame word after a random gap; predict at acceptance.
    task automatic push_frame(input frame_t f, input bit typed, input steer_t typed_res);
        int     gap;
        steer_t got;
        if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 13);
        repeat (gap) @(negedge clk) frame_valid <= 1'b0;
        @(negedge clk);
        frame_valid <= 1'b1;
        frame       <= f;
        do @(posedge clk); while (frame_ready !== 1'b1);
        got = predict_steer(f);
        steer_due.push_back(typed ? typed_res : got);
        n_frames++;
    endtask

    task automatic random_run(input int n);
        repeat (n) push_frame(next_frame(), 1'b0, '0);
    endtask

    // stop offering and wait until every predicted word is back
    task automatic settle();
        @(negedge clk) frame_valid <= 1'b0;
        while (steer_due.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_register(input logic [2:0] idx, input longint val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= 16'(val);
        case (idx)
            REG_BASE_P:      cfg_base_p = val;
            REG_BASE_D:      cfg_base_d = val;
            REG_CENTER_DUTY: cfg_center = val;
            REG_RANGE_LEFT:  cfg_left   = val;
            REG_RANGE_RIGHT: cfg_right  = val;
            default: ;
        endcase
        @(negedge clk) wr_en <= 1'b0;
    endtask

    task automatic apply_setting(input longint bp, input longint bd, input longint ctr,
                                 input longint rl, input longint rr);
        set_register(REG_BASE_P, bp);
        set_register(REG_BASE_D, bd);
        set_register(REG_CENTER_DUTY, ctr);
        set_register(REG_RANGE_LEFT, rl);
        set_register(REG_RANGE_RIGHT, rr);
        n_settings++;
    endtask

    // Receiver: random stall per word, then check against the oldest prediction.
    initial
    begin : steer_sink
        int     gap;
        steer_t want;
        steer_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
            gap = sink_calm ? 0 : $urandom_range(0, 13);
            repeat (gap) @(negedge clk) steer_ready <= 1'b0;
            @(negedge clk) steer_ready <= 1'b1;
            do @(posedge clk); while (steer_valid !== 1'b1);
            if (steer_due.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("ERROR: unexpected steer word duty=%0d drive=%0d",
                             steer.duty, steer.drive);
            end
            else
            begin
                want = steer_due.pop_front();
                n_checked++;
                if (steer.duty !== want.duty || steer.drive !== want.drive)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display(
                            "ERROR: word %0d: want duty=%0d drive=%0d, got duty=%0d drive=%0d",
                            n_checked, want.duty, want.drive, steer.duty, steer.drive);
                end
            end
        end
    end

    // Watchdog: a correct block never goes this long without some handshake.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && ((frame_valid && frame_ready) || (steer_valid && steer_ready)))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no handshake for %0d cycles, %0d words outstanding",
                 STALL_LIMIT, steer_due.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        rst_n       = 1'b0;
        frame_valid = 1'b0;
        frame       = '0;
        wr_en       = 1'b0;
        wr_index    = '0;
        wr_data     = '0;
        cfg_base_p  = BASE_P_RST;
        cfg_base_d  = BASE_D_RST;
        cfg_center  = CENTER_DUTY_RST;
        cfg_left    = RANGE_LEFT_RST;
        cfg_right   = RANGE_RIGHT_RST;
        last_err    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed frames under the reset register values
        for (i = 0; i < N_PROBES; i++)
            push_frame(frame_t'{track_error: 11'(probes[i].err), road_kind: 2'(probes[i].road)},
                       probes[i].typed,
                       steer_t'{duty: 16'(probes[i].duty), drive: 16'(probes[i].drive)});
        random_run(RUN_LEN);

        // gains and center at their floor, narrow ranges: window dips below zero duty
        settle();
        apply_setting(0, 0, 0, 41, 41);
        random_run(RUN_LEN);

        // all at their ceiling: window runs past the top of the duty range
        settle();
        apply_setting(1023, 1023, 65535, 4095, 4095);
        random_run(RUN_LEN);

        settle();
        apply_setting($urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 65535), $urandom_range(41, 4095),
                      $urandom_range(41, 4095));
        random_run(RUN_LEN);

        // lopsided windows at both ends of the duty range
        settle();
        apply_setting($urandom_range(0, 1023), $urandom_range(0, 1023), 65535, 41, 4095);
        random_run(RUN_LEN);

        settle();
        apply_setting($urandom_range(0, 1023), $urandom_range(0, 1023), 0, 4095, 41);
        random_run(RUN_LEN);

        settle();
        apply_setting($urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 65535), $urandom_range(41, 4095),
                      $urandom_range(41, 4095));
        random_run(RUN_LEN);

        // back to the power-up values, written explicitly this time
        settle();
        apply_setting(BASE_P_RST, BASE_D_RST, CENTER_DUTY_RST, RANGE_LEFT_RST,
                      RANGE_RIGHT_RST);
        random_run(RUN_LEN);

        settle();
        $display("Summary: %0d frame words, %0d steer words checked, %0d register settings",
                 n_frames, n_checked, n_settings);
        $display("Summary: %0d fuzzy-gain frames, %0d saturated drives, %0d lost-line overrides",
                 n_fuzzy, n_sat, n_forced);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
